// ===== src/scc_pkg.sv =====
// Package for the segment/circle collision unit: fixed widths, stage counts
// and the sideband vector type shared by the pipelined arithmetic units.
// No dependencies.
package scc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int DIR_FRAC_BITS = 14;

    localparam int SQ_OUT_W = 2 * DIR_FRAC_BITS + 1;
    localparam int SQ_IN_W  = 2 * SQ_OUT_W;
    localparam int SQ_REM_W = SQ_OUT_W + 1;

    localparam int DIV_Q_W   = 20;
    localparam int DIV_DEN_W = SQ_OUT_W;
    localparam int DIV_NUM_W = COORD_BITS - 1 + 2 * DIR_FRAC_BITS;

    localparam int SB_W = 148;

    localparam int PROJ_LIMIT = 92682;
    localparam int DIR_ONE    = 1 << DIR_FRAC_BITS;

    typedef logic [SB_W-1:0] scc_sb_t;

endpackage

// ===== src/scc_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on scc_pkg; carries an opaque sideband vector alongside.
module scc_sqrt
    import scc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SQ_IN_W-1:0]  in_rad,
    input  scc_sb_t             in_sb,
    output logic                out_valid,
    output logic [SQ_OUT_W-1:0] out_root,
    output scc_sb_t             out_sb
);

    logic                vld_reg  [SQ_OUT_W];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  x_reg    [SQ_OUT_W];
    scc_sb_t             sb_reg   [SQ_OUT_W];

    for (genvar i = 0; i < SQ_OUT_W; i++) begin : g_stage
        logic                vld_prev;
        logic [SQ_REM_W-1:0] rem_prev;
        logic [SQ_OUT_W-1:0] root_prev;
        logic [SQ_IN_W-1:0]  x_prev;
        scc_sb_t             sb_prev;
        logic [SQ_REM_W+1:0] work;
        logic [SQ_REM_W+1:0] trial;
        logic                take;
        logic [SQ_REM_W-1:0] rem_next;

        if (i == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign x_prev    = in_rad;
            assign sb_prev   = in_sb;
        end else begin : g_rest
            assign vld_prev  = vld_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign x_prev    = x_reg[i-1];
            assign sb_prev   = sb_reg[i-1];
        end

        assign work     = {rem_prev, x_prev[SQ_IN_W-1 -: 2]};
        assign trial    = {1'b0, root_prev, 2'b01};
        assign take     = (work >= trial);
        assign rem_next = take ? SQ_REM_W'(work - trial) : work[SQ_REM_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_prev;
            end
            if (en) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= {root_prev[SQ_OUT_W-2:0], take};
                x_reg[i]    <= {x_prev[SQ_IN_W-3:0], 2'b00};
                sb_reg[i]   <= sb_prev;
            end
        end
    end

    assign out_valid = vld_reg[SQ_OUT_W-1];
    assign out_root  = root_reg[SQ_OUT_W-1];
    assign out_sb    = sb_reg[SQ_OUT_W-1];

endmodule

// ===== src/scc_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on scc_pkg; the quotient must fit in DIV_Q_W bits.
module scc_div
    import scc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_NUM_W-1:0] in_num,
    input  logic [DIV_DEN_W-1:0] in_den,
    input  scc_sb_t              in_sb,
    output logic                 out_valid,
    output logic [DIV_Q_W-1:0]   out_quot,
    output scc_sb_t              out_sb
);

    logic                 vld_reg [DIV_Q_W];
    logic [DIV_DEN_W-1:0] rem_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0]   nq_reg  [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg [DIV_Q_W];
    scc_sb_t              sb_reg  [DIV_Q_W];

    for (genvar i = 0; i < DIV_Q_W; i++) begin : g_stage
        logic                 vld_prev;
        logic [DIV_DEN_W-1:0] rem_prev;
        logic [DIV_Q_W-1:0]   nq_prev;
        logic [DIV_DEN_W-1:0] den_prev;
        scc_sb_t              sb_prev;
        logic [DIV_DEN_W:0]   work;
        logic                 take;
        logic [DIV_DEN_W-1:0] rem_next;

        if (i == 0) begin : g_first
            assign vld_prev = in_valid;
            assign rem_prev = DIV_DEN_W'(in_num[DIV_NUM_W-1:DIV_Q_W]);
            assign nq_prev  = in_num[DIV_Q_W-1:0];
            assign den_prev = in_den;
            assign sb_prev  = in_sb;
        end else begin : g_rest
            assign vld_prev = vld_reg[i-1];
            assign rem_prev = rem_reg[i-1];
            assign nq_prev  = nq_reg[i-1];
            assign den_prev = den_reg[i-1];
            assign sb_prev  = sb_reg[i-1];
        end

        assign work     = {rem_prev, nq_prev[DIV_Q_W-1]};
        assign take     = (work >= {1'b0, den_prev});
        assign rem_next = take ? DIV_DEN_W'(work - {1'b0, den_prev}) : work[DIV_DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_prev;
            end
            if (en) begin
                rem_reg[i] <= rem_next;
                nq_reg[i]  <= {nq_prev[DIV_Q_W-2:0], take};
                den_reg[i] <= den_prev;
                sb_reg[i]  <= sb_prev;
            end
        end
    end

    assign out_valid = vld_reg[DIV_Q_W-1];
    assign out_quot  = nq_reg[DIV_Q_W-1];
    assign out_sb    = sb_reg[DIV_Q_W-1];

endmodule

// ===== src/segment_circle_collision_unit.sv =====
// Throughput: one beat per cycle unless the output stalls; the stages are two
// 29-stage square roots and three 20-stage dividers in series, a bit per stage.
// All stages advance together whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears every valid bit; no other state.
module segment_circle_collision_unit
    import scc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, center_x, center_y, radius
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // seg_vec_x, seg_vec_y, seg_proj, push_dir_x, push_dir_y, depth
    output logic [103:0] m_tdata,
    // hit
    output logic         m_tuser
);

    typedef struct packed {
        logic signed [16:0] lx;
        logic signed [16:0] ly;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        rad;
    } geo_t;

    typedef struct packed {
        logic        dneg;
        logic [33:0] dabs;
        geo_t        geo;
    } s1_t;

    typedef struct packed {
        logic        dneg;
        logic [16:0] len;
        geo_t        geo;
    } s2_t;

    typedef struct packed {
        logic        lo;
        logic        hi;
        logic        lenz;
        logic        pneg;
        logic [16:0] pmag;
        logic        lxneg;
        logic        lyneg;
        geo_t        geo;
    } fsb_t;

    typedef struct packed {
        logic               hit;
        logic               d2nz;
        logic               txneg;
        logic               tyneg;
        logic [14:0]        atx;
        logic [14:0]        aty;
        logic signed [16:0] lx;
        logic signed [16:0] ly;
        logic               pneg;
        logic [16:0]        pmag;
        logic [14:0]        rad;
    } s3_t;

    typedef struct packed {
        logic               hit;
        logic               d2nz;
        logic               txneg;
        logic               tyneg;
        logic signed [16:0] lx;
        logic signed [16:0] ly;
        logic               pneg;
        logic [16:0]        pmag;
        logic [15:0]        depth;
    } s4_t;

    logic pipe_en;
    logic m_tvalid_reg;
    logic [103:0] m_tdata_reg;
    logic m_tuser_reg;

    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Stage A: differences.
    logic signed [15:0] in_sx, in_sy, in_ex, in_ey, in_cx, in_cy;
    logic [14:0] in_rad;
    geo_t a_geo_next;
    logic signed [16:0] a_vx_next, a_vy_next;
    logic a_vld_reg;
    geo_t a_geo_reg;
    logic signed [16:0] a_vx_reg, a_vy_reg;

    assign in_sx  = s_tdata[15:0];
    assign in_sy  = s_tdata[31:16];
    assign in_ex  = s_tdata[47:32];
    assign in_ey  = s_tdata[63:48];
    assign in_cx  = s_tdata[79:64];
    assign in_cy  = s_tdata[95:80];
    assign in_rad = s_tdata[110:96];

    always_comb begin
        a_geo_next.lx  = {in_ex[15], in_ex} - {in_sx[15], in_sx};
        a_geo_next.ly  = {in_ey[15], in_ey} - {in_sy[15], in_sy};
        a_geo_next.ax  = in_sx;
        a_geo_next.ay  = in_sy;
        a_geo_next.cx  = in_cx;
        a_geo_next.cy  = in_cy;
        a_geo_next.rad = in_rad;
        a_vx_next      = {in_cx[15], in_cx} - {in_sx[15], in_sx};
        a_vy_next      = {in_cy[15], in_cy} - {in_sy[15], in_sy};
    end

    // Stage B: products. Stage C: sums. Stage D: dot magnitude.
    logic b_vld_reg, c_vld_reg, d_vld_reg;
    geo_t b_geo_reg, c_geo_reg, d_geo_reg;
    logic signed [33:0] b_lxx_reg, b_lyy_reg, b_dx_reg, b_dy_reg;
    logic [33:0] c_ll_reg, d_ll_reg;
    logic signed [34:0] c_dot_reg;
    logic d_dneg_reg;
    logic [33:0] d_dabs_reg;
    logic [33:0] d_dabs_next;

    assign d_dabs_next = c_dot_reg[34] ? 34'(-c_dot_reg) : c_dot_reg[33:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            a_vld_reg <= s_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
        if (pipe_en) begin
            a_geo_reg  <= a_geo_next;
            a_vx_reg   <= a_vx_next;
            a_vy_reg   <= a_vy_next;
            b_geo_reg  <= a_geo_reg;
            b_lxx_reg  <= 34'(a_geo_reg.lx) * 34'(a_geo_reg.lx);
            b_lyy_reg  <= 34'(a_geo_reg.ly) * 34'(a_geo_reg.ly);
            b_dx_reg   <= 34'(a_geo_reg.lx) * 34'(a_vx_reg);
            b_dy_reg   <= 34'(a_geo_reg.ly) * 34'(a_vy_reg);
            c_geo_reg  <= b_geo_reg;
            c_ll_reg   <= 34'(b_lxx_reg) + 34'(b_lyy_reg);
            c_dot_reg  <= 35'(b_dx_reg) + 35'(b_dy_reg);
            d_geo_reg  <= c_geo_reg;
            d_ll_reg   <= c_ll_reg;
            d_dneg_reg <= c_dot_reg[34];
            d_dabs_reg <= d_dabs_next;
        end
    end

    // Segment length.
    s1_t sq1_in_s;
    scc_sb_t sq1_in_sb, sq1_out_sb;
    logic sq1_vld;
    logic [SQ_OUT_W-1:0] sq1_root;
    s1_t sq1_o;

    assign sq1_in_s = '{dneg: d_dneg_reg, dabs: d_dabs_reg, geo: d_geo_reg};
    assign sq1_in_sb = SB_W'(sq1_in_s);

    scc_sqrt u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (d_vld_reg),
        .in_rad    (SQ_IN_W'(d_ll_reg)),
        .in_sb     (sq1_in_sb),
        .out_valid (sq1_vld),
        .out_root  (sq1_root),
        .out_sb    (sq1_out_sb)
    );

    assign sq1_o = s1_t'(sq1_out_sb[$bits(s1_t)-1:0]);

    // Projection length.
    s2_t dv1_in_s;
    scc_sb_t dv1_in_sb, dv1_out_sb;
    logic dv1_vld;
    logic [DIV_Q_W-1:0] dv1_quot;
    s2_t dv1_o;

    assign dv1_in_s  = '{dneg: sq1_o.dneg, len: sq1_root[16:0], geo: sq1_o.geo};
    assign dv1_in_sb = SB_W'(dv1_in_s);

    scc_div u_proj_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sq1_vld),
        .in_num    (DIV_NUM_W'(sq1_o.dabs)),
        .in_den    (sq1_root),
        .in_sb     (dv1_in_sb),
        .out_valid (dv1_vld),
        .out_quot  (dv1_quot),
        .out_sb    (dv1_out_sb)
    );

    assign dv1_o = s2_t'(dv1_out_sb[$bits(s2_t)-1:0]);

    // Stage E: clamp decision. Stage F: offset products.
    fsb_t e_f_next;
    logic [DIV_Q_W-1:0] e_q;
    logic e_lenz;
    logic [16:0] e_qm_next;
    logic e_vld_reg, f_vld_reg;
    fsb_t e_f_reg, f_f_reg;
    logic [16:0] e_qm_reg, e_len_reg, f_len_reg;
    logic [15:0] e_alx_reg, e_aly_reg;
    logic [32:0] f_pxm_reg, f_pym_reg;

    always_comb begin
        e_lenz          = (dv1_o.len == '0);
        e_q             = e_lenz ? '0 : dv1_quot;
        e_f_next.lo     = dv1_o.dneg && (e_q != '0);
        e_f_next.hi     = !dv1_o.dneg && (e_q > DIV_Q_W'(dv1_o.len));
        e_f_next.lenz   = e_lenz;
        e_f_next.pneg   = dv1_o.dneg;
        e_f_next.pmag   = (e_q > DIV_Q_W'(PROJ_LIMIT)) ? 17'(PROJ_LIMIT) : e_q[16:0];
        e_f_next.lxneg  = dv1_o.geo.lx[16];
        e_f_next.lyneg  = dv1_o.geo.ly[16];
        e_f_next.geo    = dv1_o.geo;
        e_qm_next       = (e_f_next.lo || e_f_next.hi) ? '0 : e_q[16:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            e_vld_reg <= dv1_vld;
            f_vld_reg <= e_vld_reg;
        end
        if (pipe_en) begin
            e_f_reg   <= e_f_next;
            e_qm_reg  <= e_qm_next;
            e_len_reg <= dv1_o.len;
            e_alx_reg <= dv1_o.geo.lx[16] ? 16'(-dv1_o.geo.lx) : dv1_o.geo.lx[15:0];
            e_aly_reg <= dv1_o.geo.ly[16] ? 16'(-dv1_o.geo.ly) : dv1_o.geo.ly[15:0];
            f_f_reg   <= e_f_reg;
            f_len_reg <= e_len_reg;
            f_pxm_reg <= 33'(e_alx_reg) * 33'(e_qm_reg);
            f_pym_reg <= 33'(e_aly_reg) * 33'(e_qm_reg);
        end
    end

    // Closest point offsets along the segment.
    scc_sb_t f_sb, dvx_out_sb;
    logic dvx_vld;
    logic [DIV_Q_W-1:0] dvx_quot, dvy_quot;
    fsb_t g_f;

    assign f_sb = SB_W'(f_f_reg);

    scc_div u_offx_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (f_vld_reg),
        .in_num    (DIV_NUM_W'(f_pxm_reg)),
        .in_den    (DIV_DEN_W'(f_len_reg)),
        .in_sb     (f_sb),
        .out_valid (dvx_vld),
        .out_quot  (dvx_quot),
        .out_sb    (dvx_out_sb)
    );

    scc_div u_offy_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (f_vld_reg),
        .in_num    (DIV_NUM_W'(f_pym_reg)),
        .in_den    (DIV_DEN_W'(f_len_reg)),
        .in_sb     (f_sb),
        .out_valid (),
        .out_quot  (dvy_quot),
        .out_sb    ()
    );

    assign g_f = fsb_t'(dvx_out_sb[$bits(fsb_t)-1:0]);

    // Stages G to L: closest point, center offset, squared distance, hit.
    logic g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg, k_vld_reg, l_vld_reg;
    fsb_t g_f_reg, h_f_reg, i_f_reg, j_f_reg, k_f_reg;
    logic signed [17:0] g_offx_reg, g_offy_reg;
    logic signed [17:0] h_qx_reg, h_qy_reg;
    logic signed [17:0] i_tx_reg, i_ty_reg, j_tx_reg, j_ty_reg, k_tx_reg, k_ty_reg;
    logic signed [35:0] j_txx_reg, j_tyy_reg;
    logic [29:0] j_rr_reg, k_rr_reg;
    logic [33:0] k_d2_reg;
    logic signed [17:0] h_selx, h_sely;
    logic [17:0] l_atx_full, l_aty_full;
    s3_t l_s_reg;
    logic [29:0] l_d2lo_reg;

    always_comb begin
        if (g_f_reg.lo) begin
            h_selx = '0;
            h_sely = '0;
        end else if (g_f_reg.hi) begin
            h_selx = 18'(g_f_reg.geo.lx);
            h_sely = 18'(g_f_reg.geo.ly);
        end else begin
            h_selx = g_offx_reg;
            h_sely = g_offy_reg;
        end
        l_atx_full = k_tx_reg[17] ? 18'(-k_tx_reg) : k_tx_reg;
        l_aty_full = k_ty_reg[17] ? 18'(-k_ty_reg) : k_ty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            g_vld_reg <= dvx_vld;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
            k_vld_reg <= j_vld_reg;
            l_vld_reg <= k_vld_reg;
        end
        if (pipe_en) begin
            g_f_reg    <= g_f;
            g_offx_reg <= g_f.lenz ? '0 :
                          (g_f.lxneg ? 18'(-dvx_quot) : 18'(dvx_quot));
            g_offy_reg <= g_f.lenz ? '0 :
                          (g_f.lyneg ? 18'(-dvy_quot) : 18'(dvy_quot));
            h_f_reg    <= g_f_reg;
            h_qx_reg   <= 18'(g_f_reg.geo.ax) + h_selx;
            h_qy_reg   <= 18'(g_f_reg.geo.ay) + h_sely;
            i_f_reg    <= h_f_reg;
            i_tx_reg   <= 18'(h_f_reg.geo.cx) - h_qx_reg;
            i_ty_reg   <= 18'(h_f_reg.geo.cy) - h_qy_reg;
            j_f_reg    <= i_f_reg;
            j_tx_reg   <= i_tx_reg;
            j_ty_reg   <= i_ty_reg;
            j_txx_reg  <= 36'(i_tx_reg) * 36'(i_tx_reg);
            j_tyy_reg  <= 36'(i_ty_reg) * 36'(i_ty_reg);
            j_rr_reg   <= 30'(i_f_reg.geo.rad) * 30'(i_f_reg.geo.rad);
            k_f_reg    <= j_f_reg;
            k_tx_reg   <= j_tx_reg;
            k_ty_reg   <= j_ty_reg;
            k_d2_reg   <= j_txx_reg[33:0] + j_tyy_reg[33:0];
            k_rr_reg   <= j_rr_reg;
            l_s_reg.hit   <= (k_d2_reg < 34'(k_rr_reg));
            l_s_reg.d2nz  <= (k_d2_reg != '0);
            l_s_reg.txneg <= k_tx_reg[17];
            l_s_reg.tyneg <= k_ty_reg[17];
            l_s_reg.atx   <= l_atx_full[14:0];
            l_s_reg.aty   <= l_aty_full[14:0];
            l_s_reg.lx    <= k_f_reg.geo.lx;
            l_s_reg.ly    <= k_f_reg.geo.ly;
            l_s_reg.pneg  <= k_f_reg.pneg;
            l_s_reg.pmag  <= k_f_reg.pmag;
            l_s_reg.rad   <= k_f_reg.geo.rad;
            l_d2lo_reg    <= k_d2_reg[29:0];
        end
    end

    // Distance scaled by the direction fraction.
    scc_sb_t sq2_in_sb, sq2_out_sb;
    logic sq2_vld;
    logic [SQ_OUT_W-1:0] sq2_root;
    s3_t sq2_o;
    s4_t dv2_in_s;
    scc_sb_t dv2_in_sb, dv2x_out_sb;
    logic [15:0] sq2_depth;

    assign sq2_in_sb = SB_W'(l_s_reg);

    scc_sqrt u_dist_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (l_vld_reg),
        .in_rad    (SQ_IN_W'({l_d2lo_reg, (2 * DIR_FRAC_BITS)'(0)})),
        .in_sb     (sq2_in_sb),
        .out_valid (sq2_vld),
        .out_root  (sq2_root),
        .out_sb    (sq2_out_sb)
    );

    assign sq2_o = s3_t'(sq2_out_sb[$bits(s3_t)-1:0]);

    // Rounded distance is the integer part plus the first fraction bit.
    assign sq2_depth = 16'(sq2_root[SQ_OUT_W-1:DIR_FRAC_BITS]) - 16'(sq2_o.rad)
                     + 16'(sq2_root[DIR_FRAC_BITS-1]);

    assign dv2_in_s = '{hit: sq2_o.hit, d2nz: sq2_o.d2nz, txneg: sq2_o.txneg,
                        tyneg: sq2_o.tyneg, lx: sq2_o.lx, ly: sq2_o.ly,
                        pneg: sq2_o.pneg, pmag: sq2_o.pmag, depth: sq2_depth};
    assign dv2_in_sb = SB_W'(dv2_in_s);

    logic dv2_vld;
    logic [DIV_Q_W-1:0] dirx_quot, diry_quot;
    s4_t n_s;

    scc_div u_dirx_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sq2_vld),
        .in_num    (DIV_NUM_W'({sq2_o.atx, (2 * DIR_FRAC_BITS)'(0)})),
        .in_den    (sq2_root),
        .in_sb     (dv2_in_sb),
        .out_valid (dv2_vld),
        .out_quot  (dirx_quot),
        .out_sb    (dv2x_out_sb)
    );

    scc_div u_diry_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sq2_vld),
        .in_num    (DIV_NUM_W'({sq2_o.aty, (2 * DIR_FRAC_BITS)'(0)})),
        .in_den    (sq2_root),
        .in_sb     (dv2_in_sb),
        .out_valid (),
        .out_quot  (diry_quot),
        .out_sb    ()
    );

    assign n_s = s4_t'(dv2x_out_sb[$bits(s4_t)-1:0]);

    // Output stage.
    logic [15:0] n_px, n_py, n_dirx, n_diry;
    logic [17:0] n_proj;
    logic [103:0] m_tdata_next;

    always_comb begin
        n_px   = (dirx_quot > DIV_Q_W'(DIR_ONE)) ? 16'(DIR_ONE) : dirx_quot[15:0];
        n_py   = (diry_quot > DIV_Q_W'(DIR_ONE)) ? 16'(DIR_ONE) : diry_quot[15:0];
        n_dirx = !n_s.d2nz ? '0 : (n_s.txneg ? 16'(-n_px) : n_px);
        n_diry = !n_s.d2nz ? '0 : (n_s.tyneg ? 16'(-n_py) : n_py);
        n_proj = n_s.pneg ? 18'(-n_s.pmag) : 18'(n_s.pmag);
        if (n_s.hit) begin
            m_tdata_next = {4'b0000, n_s.depth, n_diry, n_dirx, n_proj, n_s.ly, n_s.lx};
        end else begin
            m_tdata_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_tvalid_reg <= dv2_vld;
        end
        if (pipe_en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= n_s.hit;
        end
    end

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("Miss beat carries nonzero data.");
    a_depth_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> $signed(m_tdata[99:84]) <= 16'sd0)
        else $error("Positive penetration depth on a hit.");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("Input taken while a result is stalled.");
`endif

endmodule
